[rtl/fhsc_pkg.sv]
package fhsc_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FLOOR_W    = 12;
  localparam int THR_W      = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  // stored angles must hold both an input angle and the floor register
  localparam int ANG_W      = (ANGLE_BITS > FLOOR_W) ? ANGLE_BITS : FLOOR_W;
  // compare domain: room for threshold + band (up to 4094) and sign
  localparam int CMP_W      = ANG_W + 2;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [CMP_W-1:0] cmp_t;

  // op codes
  localparam logic [1:0] OP_ANGLE = 2'd0;
  localparam logic [1:0] OP_HALL  = 2'd1;
  localparam logic [1:0] OP_TENT  = 2'd2;

  // hall codes
  localparam logic signed [1:0] HALL_CLOSED = 2'sd0;
  localparam logic signed [1:0] HALL_OPEN   = 2'sd1;

  // fold states
  localparam logic [1:0] FS_UNKNOWN = 2'd0;
  localparam logic [1:0] FS_EXPAND  = 2'd1;
  localparam logic [1:0] FS_FOLDED  = 2'd2;
  localparam logic [1:0] FS_HALF    = 2'd3;

  // tent modes
  localparam logic [1:0] TENT_OFF   = 2'd0;
  localparam logic [1:0] TENT_ON    = 2'd1;
  localparam logic [1:0] TENT_HOVER = 2'd2;

  // device status
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_FOLDED  = 2'd1;
  localparam logic [1:0] ST_TENT    = 2'd2;
  localparam logic [1:0] ST_HOVER   = 2'd3;

  // tent reports
  localparam logic [2:0] RPT_NONE      = 3'd0;
  localparam logic [2:0] RPT_ENTER     = 3'd1;
  localparam logic [2:0] RPT_EXIT      = 3'd2;
  localparam logic [2:0] RPT_ABN_HALL  = 3'd3;
  localparam logic [2:0] RPT_ABN_ANGLE = 3'd4;

  // hover events
  localparam logic [1:0] HOV_NONE   = 2'd0;
  localparam logic [1:0] HOV_TENT   = 2'd1;
  localparam logic [1:0] HOV_HOVER  = 2'd2;
  localparam logic [1:0] HOV_CANCEL = 2'd3;

  // tent exit limits, tenths of a degree
  localparam cmp_t TENT_EXIT_MIN = cmp_t'(50);
  localparam cmp_t TENT_EXIT_MAX = cmp_t'(1750);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_HALF_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_HALF_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_ANGLE    = 3'd5;

  // register reset values
  localparam logic [FLOOR_W-1:0] RST_ANGLE_FLOOR    = 12'd0;
  localparam logic [THR_W-1:0]   RST_OPEN_HALF_MIN  = 11'd250;
  localparam logic [THR_W-1:0]   RST_CLOSE_HALF_MIN = 11'd850;
  localparam logic [THR_W-1:0]   RST_HALF_MAX       = 11'd1550;
  localparam logic [THR_W-1:0]   RST_HYST_BAND      = 11'd100;
  localparam logic [THR_W-1:0]   RST_LARGE_ANGLE    = 11'd500;

  typedef struct packed {
    logic [FLOOR_W-1:0] angle_floor;
    logic [THR_W-1:0]   open_half_min;
    logic [THR_W-1:0]   close_half_min;
    logic [THR_W-1:0]   half_max;
    logic [THR_W-1:0]   hysteresis_band;
    logic [THR_W-1:0]   large_boundary_angle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [ANGLE_BITS-1:0] angle;
    logic [1:0]            hall;
    logic [1:0]            tent_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0] fold_state;
    logic [1:0] tent_mode;
    logic [1:0] device_status;
    logic [2:0] tent_report;
    logic [1:0] hover_event;
    logic       hover_hall_closed;
    logic       wake_request;
  } out_item_t;

endpackage

[rtl/fhsc_in_if.sv]
interface fhsc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            op;
  logic signed [fhsc_pkg::ANGLE_BITS-1:0] angle;
  logic signed [1:0]                     hall;
  logic [1:0]                            tent_type;

  modport source (output valid, output op, output angle, output hall, output tent_type,
                  input ready);
  modport sink (input valid, input op, input angle, input hall, input tent_type,
                output ready);
endinterface

[rtl/fhsc_out_if.sv]
interface fhsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] fold_state;
  logic [1:0] tent_mode;
  logic [1:0] device_status;
  logic [2:0] tent_report;
  logic [1:0] hover_event;
  logic       hover_hall_closed;
  logic       wake_request;

  modport source (output valid, output fold_state, output tent_mode, output device_status,
                  output tent_report, output hover_event, output hover_hall_closed,
                  output wake_request, input ready);
  modport sink (input valid, input fold_state, input tent_mode, input device_status,
                input tent_report, input hover_event, input hover_hall_closed,
                input wake_request, output ready);
endinterface

[rtl/fold_hinge_state_classifier_top.sv]
// Fold hinge state classifier. Takes angle, hall and tent events on in_if and returns
// exactly one result beat per event on out_if, carrying the fold state, tent mode and
// device status after the event plus any tent/hover events it raised. One event is
// accepted every cycle while out_if is ready; it passes the input register, then the
// result register. The rate is set by the state loop: each event's classification
// and state update go through the comparator logic combinationally so the next event
// sees it. Registers on the cfg_ port may be written only while no event is in flight.
module fold_hinge_state_classifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  fhsc_in_if.sink                        in_if,
  fhsc_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [fhsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fhsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fhsc_pkg::cfg_t      cfg;
  logic                in_valid_r, in_valid_nxt;
  fhsc_pkg::in_item_t  in_item_r;
  logic                out_valid_r, out_valid_nxt;
  fhsc_pkg::out_item_t out_item_r;
  fhsc_pkg::out_item_t result;
  logic                advance;
  logic                fire;
  logic                in_beat;

  fhsc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  assign advance     = !out_valid_r || out_if.ready;
  assign fire        = in_valid_r && advance;
  assign in_if.ready = !in_valid_r || advance;
  assign in_beat     = in_if.valid && in_if.ready;

  fhsc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .item   (in_item_r),
    .result (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_beat)
      in_valid_nxt = 1'b1;
    else if (fire)
      in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (fire)
      out_valid_nxt = 1'b1;
    else if (out_if.ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_item_r.op        <= in_if.op;
      in_item_r.angle     <= in_if.angle;
      in_item_r.hall      <= in_if.hall;
      in_item_r.tent_type <= in_if.tent_type;
    end
    if (fire)
      out_item_r <= result;
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.fold_state        = out_item_r.fold_state;
  assign out_if.tent_mode         = out_item_r.tent_mode;
  assign out_if.device_status     = out_item_r.device_status;
  assign out_if.tent_report       = out_item_r.tent_report;
  assign out_if.hover_event       = out_item_r.hover_event;
  assign out_if.hover_hall_closed = out_item_r.hover_hall_closed;
  assign out_if.wake_request      = out_item_r.wake_request;

  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_valid_r)
    else $error("accepted beat lost from input register");

  a_wake_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.wake_request) |->
      (out_item_r.hover_event == fhsc_pkg::HOV_CANCEL &&
       (out_item_r.tent_report == fhsc_pkg::RPT_ABN_HALL ||
        out_item_r.tent_report == fhsc_pkg::RPT_ABN_ANGLE)))
    else $error("wake request without abnormal tent exit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_item_r)))
    else $error("result beat changed while stalled");

endmodule

[rtl/fhsc_cfg_regs.sv]
module fhsc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [fhsc_pkg::CFG_IDX_W-1:0]  idx,
  input  logic [fhsc_pkg::CFG_DATA_W-1:0] wdata,
  output fhsc_pkg::cfg_t                 cfg
);

  fhsc_pkg::cfg_t cfg_r;
  fhsc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (idx)
        fhsc_pkg::CFG_ANGLE_FLOOR:    cfg_nxt.angle_floor = wdata[fhsc_pkg::FLOOR_W-1:0];
        fhsc_pkg::CFG_OPEN_HALF_MIN:  cfg_nxt.open_half_min = wdata[fhsc_pkg::THR_W-1:0];
        fhsc_pkg::CFG_CLOSE_HALF_MIN: cfg_nxt.close_half_min = wdata[fhsc_pkg::THR_W-1:0];
        fhsc_pkg::CFG_HALF_MAX:       cfg_nxt.half_max = wdata[fhsc_pkg::THR_W-1:0];
        fhsc_pkg::CFG_HYST_BAND:      cfg_nxt.hysteresis_band = wdata[fhsc_pkg::THR_W-1:0];
        fhsc_pkg::CFG_LARGE_ANGLE:    cfg_nxt.large_boundary_angle =
                                        wdata[fhsc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_floor          <= fhsc_pkg::RST_ANGLE_FLOOR;
      cfg_r.open_half_min        <= fhsc_pkg::RST_OPEN_HALF_MIN;
      cfg_r.close_half_min       <= fhsc_pkg::RST_CLOSE_HALF_MIN;
      cfg_r.half_max             <= fhsc_pkg::RST_HALF_MAX;
      cfg_r.hysteresis_band      <= fhsc_pkg::RST_HYST_BAND;
      cfg_r.large_boundary_angle <= fhsc_pkg::RST_LARGE_ANGLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/fhsc_classify.sv]
module fhsc_classify (
  input  fhsc_pkg::cfg_t    cfg,
  input  fhsc_pkg::cmp_t    a,
  input  logic signed [1:0] hall,
  input  logic [1:0]        cur,
  input  logic              mode_cur,
  output logic [1:0]        st,
  output logic              mode_nxt
);

  fhsc_pkg::cmp_t floor_c;
  fhsc_pkg::cmp_t open_min_c;
  fhsc_pkg::cmp_t close_min_c;
  fhsc_pkg::cmp_t half_max_c;
  fhsc_pkg::cmp_t band_c;
  fhsc_pkg::cmp_t large_c;
  logic           closed;
  logic           open;
  logic [1:0]     hold;

  always_comb begin
    floor_c     = fhsc_pkg::cmp_t'($signed(cfg.angle_floor));
    open_min_c  = fhsc_pkg::cmp_t'(cfg.open_half_min);
    close_min_c = fhsc_pkg::cmp_t'(cfg.close_half_min);
    half_max_c  = fhsc_pkg::cmp_t'(cfg.half_max);
    band_c      = fhsc_pkg::cmp_t'(cfg.hysteresis_band);
    large_c     = fhsc_pkg::cmp_t'(cfg.large_boundary_angle);
    closed      = (hall == fhsc_pkg::HALL_CLOSED);
    open        = (hall == fhsc_pkg::HALL_OPEN);
    hold        = (cur == fhsc_pkg::FS_UNKNOWN) ? fhsc_pkg::FS_HALF : cur;

    // boundary mode moves even when the angle is under the floor
    if (closed)
      mode_nxt = 1'b0;
    else if (a >= large_c)
      mode_nxt = 1'b1;
    else
      mode_nxt = mode_cur;

    if (a < floor_c)
      st = cur;
    else if (!mode_nxt) begin
      if (a <= open_min_c && closed)
        st = fhsc_pkg::FS_FOLDED;
      else if (a >= open_min_c + band_c && closed)
        st = fhsc_pkg::FS_HALF;
      else if (a <= half_max_c - band_c && open)
        st = fhsc_pkg::FS_HALF;
      else if (a >= half_max_c)
        st = fhsc_pkg::FS_EXPAND;
      else
        st = hold;
    end else begin
      if (open && a == open_min_c)
        st = cur;
      else if (a <= close_min_c)
        st = fhsc_pkg::FS_FOLDED;
      else if (a <= half_max_c - band_c && a > close_min_c + band_c)
        st = fhsc_pkg::FS_HALF;
      else if (a >= half_max_c)
        st = fhsc_pkg::FS_EXPAND;
      else
        st = hold;
    end
  end

endmodule

[rtl/fhsc_core.sv]
module fhsc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  fhsc_pkg::cfg_t      cfg,
  input  logic                fire,
  input  fhsc_pkg::in_item_t  item,
  output fhsc_pkg::out_item_t result
);

  logic [1:0]     fold_status_r, fold_status_nxt;
  logic           large_mode_r, large_mode_nxt;
  fhsc_pkg::ang_t last_angle_r, last_angle_nxt;
  logic           last_hall_r, last_hall_nxt;
  logic [1:0]     tent_state_r, tent_state_nxt;
  logic [1:0]     status_code_r, status_code_nxt;

  logic signed [1:0]              hall;
  logic signed [fhsc_pkg::ANGLE_BITS-1:0] angle;
  fhsc_pkg::ang_t                 floor_a;
  fhsc_pkg::cmp_t                 a_cmp;
  fhsc_pkg::cmp_t                 cls_a;
  logic signed [1:0]              cls_hall;
  logic [1:0]                     cls_st;
  logic                           cls_mode;
  logic                           req_ok;

  assign hall    = $signed(item.hall);
  assign angle   = $signed(item.angle);
  assign floor_a = fhsc_pkg::ang_t'($signed(cfg.angle_floor));
  assign a_cmp   = fhsc_pkg::cmp_t'(angle);

  // tent-off: stored angle, or floor if closed; stored hall if <0
  always_comb begin
    if (item.op == fhsc_pkg::OP_TENT) begin
      cls_a    = (hall == fhsc_pkg::HALL_CLOSED) ? fhsc_pkg::cmp_t'(floor_a)
                                                 : fhsc_pkg::cmp_t'(last_angle_r);
      cls_hall = hall[1] ? $signed({1'b0, last_hall_r}) : hall;
    end else begin
      cls_a    = a_cmp;
      cls_hall = hall;
    end
  end

  fhsc_classify u_classify (
    .cfg      (cfg),
    .a        (cls_a),
    .hall     (cls_hall),
    .cur      (fold_status_r),
    .mode_cur (large_mode_r),
    .st       (cls_st),
    .mode_nxt (cls_mode)
  );

  always_comb begin
    fold_status_nxt = fold_status_r;
    large_mode_nxt  = large_mode_r;
    last_angle_nxt  = last_angle_r;
    last_hall_nxt   = last_hall_r;
    tent_state_nxt  = tent_state_r;
    status_code_nxt = status_code_r;
    result.tent_report       = fhsc_pkg::RPT_NONE;
    result.hover_event       = fhsc_pkg::HOV_NONE;
    result.hover_hall_closed = 1'b0;
    result.wake_request      = 1'b0;
    req_ok = (item.tent_type == fhsc_pkg::TENT_OFF) || (item.tent_type == fhsc_pkg::TENT_ON)
          || (item.tent_type == fhsc_pkg::TENT_HOVER);

    case (item.op)
      fhsc_pkg::OP_ANGLE, fhsc_pkg::OP_HALL: begin
        if (item.op == fhsc_pkg::OP_ANGLE)
          last_angle_nxt = fhsc_pkg::ang_t'(angle);
        else
          last_hall_nxt = (hall != fhsc_pkg::HALL_CLOSED);
        if (tent_state_r != fhsc_pkg::TENT_OFF) begin
          if (hall == fhsc_pkg::HALL_CLOSED || a_cmp < fhsc_pkg::TENT_EXIT_MIN
              || a_cmp > fhsc_pkg::TENT_EXIT_MAX) begin
            result.tent_report = (hall == fhsc_pkg::HALL_CLOSED) ? fhsc_pkg::RPT_ABN_HALL
                                                                 : fhsc_pkg::RPT_ABN_ANGLE;
            fold_status_nxt = cls_st;
            large_mode_nxt  = cls_mode;
            tent_state_nxt  = fhsc_pkg::TENT_OFF;
            status_code_nxt = (cls_st == fhsc_pkg::FS_FOLDED) ? fhsc_pkg::ST_FOLDED
                                                              : fhsc_pkg::ST_UNKNOWN;
            result.hover_event       = fhsc_pkg::HOV_CANCEL;
            result.hover_hall_closed = (hall != fhsc_pkg::HALL_OPEN);
            result.wake_request      = 1'b1;
          end
        end else begin
          fold_status_nxt = cls_st;
          large_mode_nxt  = cls_mode;
        end
      end
      fhsc_pkg::OP_TENT: begin
        if (req_ok && item.tent_type != tent_state_r) begin
          tent_state_nxt = item.tent_type;
          if (item.tent_type != fhsc_pkg::TENT_OFF) begin
            result.tent_report = fhsc_pkg::RPT_ENTER;
            fold_status_nxt    = fhsc_pkg::FS_FOLDED;
            if (item.tent_type == fhsc_pkg::TENT_ON) begin
              status_code_nxt    = fhsc_pkg::ST_TENT;
              result.hover_event = fhsc_pkg::HOV_TENT;
            end else begin
              status_code_nxt    = fhsc_pkg::ST_HOVER;
              result.hover_event = fhsc_pkg::HOV_HOVER;
            end
          end else begin
            if (hall == fhsc_pkg::HALL_CLOSED)
              last_angle_nxt = floor_a;
            fold_status_nxt = cls_st;
            large_mode_nxt  = cls_mode;
            status_code_nxt = (cls_st == fhsc_pkg::FS_FOLDED) ? fhsc_pkg::ST_FOLDED
                                                              : fhsc_pkg::ST_UNKNOWN;
            result.tent_report       = fhsc_pkg::RPT_EXIT;
            result.hover_event       = fhsc_pkg::HOV_CANCEL;
            result.hover_hall_closed = (hall != fhsc_pkg::HALL_OPEN);
          end
        end
      end
      default: ;
    endcase

    result.fold_state    = fold_status_nxt;
    result.tent_mode     = tent_state_nxt;
    result.device_status = status_code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_status_r <= fhsc_pkg::FS_UNKNOWN;
      large_mode_r  <= 1'b0;
      last_angle_r  <= fhsc_pkg::ang_t'($signed(fhsc_pkg::RST_ANGLE_FLOOR));
      last_hall_r   <= 1'b1;
      tent_state_r  <= fhsc_pkg::TENT_OFF;
      status_code_r <= fhsc_pkg::ST_UNKNOWN;
    end else if (fire) begin
      fold_status_r <= fold_status_nxt;
      large_mode_r  <= large_mode_nxt;
      last_angle_r  <= last_angle_nxt;
      last_hall_r   <= last_hall_nxt;
      tent_state_r  <= tent_state_nxt;
      status_code_r <= status_code_nxt;
    end
  end

  // entering tent forces folded, and nothing but an exit changes it
  a_tent_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (tent_state_r != fhsc_pkg::TENT_OFF) |-> (fold_status_r == fhsc_pkg::FS_FOLDED))
    else $error("tent mode active without folded state");

  a_tent_status: assert property (@(posedge clk) disable iff (!rst_n)
    ((tent_state_r == fhsc_pkg::TENT_ON) |-> (status_code_r == fhsc_pkg::ST_TENT)) and
    ((tent_state_r == fhsc_pkg::TENT_HOVER) |-> (status_code_r == fhsc_pkg::ST_HOVER)))
    else $error("device status does not match tent mode");

  a_off_status: assert property (@(posedge clk) disable iff (!rst_n)
    (tent_state_r == fhsc_pkg::TENT_OFF) |->
      (status_code_r == fhsc_pkg::ST_UNKNOWN || status_code_r == fhsc_pkg::ST_FOLDED))
    else $error("tent status left behind after tent exit");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // codes the package has no name for, and int copies of the hall codes
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] TENT_BAD = 2'd3;
  localparam int HALL_STORED = -1;
  localparam int HALL_STORED_ALT = -2;
  localparam int HALL_CLOSED_I = int'(fhsc_pkg::HALL_CLOSED);
  localparam int HALL_OPEN_I = int'(fhsc_pkg::HALL_OPEN);
  localparam logic [fhsc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [fhsc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  localparam int ROUNDS = 8;
  localparam int ROUND_ITEMS = 180;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    fhsc_pkg::in_item_t  stim;
    logic                typed;
    fhsc_pkg::out_item_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [fhsc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [fhsc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  fhsc_in_if in_bus ();
  fhsc_out_if out_bus ();

  fold_hinge_state_classifier_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_bus),
    .out_if   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the classifier state and registers
  logic [1:0] fold_q, tent_q, status_q;
  logic wide_mode;
  int last_ang, last_hall_q;
  int floor_q, thr_open, thr_close, thr_half, thr_band, thr_large;

  fhsc_pkg::out_item_t result_q[$];
  fhsc_pkg::out_item_t want_res, got_res;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  dir_row_t dir_tab[$];

  function automatic logic [1:0] classify_fold(int a, int h);
    logic [1:0] cur, st;
    cur = fold_q;
    if (h == HALL_CLOSED_I) wide_mode = 1'b0;
    else if (a >= thr_large) wide_mode = 1'b1;
    if (a < floor_q) return cur;
    if (!wide_mode) begin
      if (a <= thr_open && h == HALL_CLOSED_I) st = fhsc_pkg::FS_FOLDED;
      else if (a >= thr_open + thr_band && h == HALL_CLOSED_I) st = fhsc_pkg::FS_HALF;
      else if (a <= thr_half - thr_band && h == HALL_OPEN_I) st = fhsc_pkg::FS_HALF;
      else if (a >= thr_half) st = fhsc_pkg::FS_EXPAND;
      else st = (cur == fhsc_pkg::FS_UNKNOWN) ? fhsc_pkg::FS_HALF : cur;
    end else begin
      if (h == HALL_OPEN_I && a == thr_open) st = cur;
      else if (a <= thr_close) st = fhsc_pkg::FS_FOLDED;
      else if (a <= thr_half - thr_band && a > thr_close + thr_band) st = fhsc_pkg::FS_HALF;
      else if (a >= thr_half) st = fhsc_pkg::FS_EXPAND;
      else st = (cur == fhsc_pkg::FS_UNKNOWN) ? fhsc_pkg::FS_HALF : cur;
    end
    return st;
  endfunction

  function automatic fhsc_pkg::out_item_t predict_event(fhsc_pkg::in_item_t it);
    fhsc_pkg::out_item_t r;
    int a, h;
    logic [1:0] nx;
    a = int'($signed(it.angle));
    h = int'($signed(it.hall));
    r = '0;
    if (it.op == fhsc_pkg::OP_ANGLE || it.op == fhsc_pkg::OP_HALL) begin
      if (it.op == fhsc_pkg::OP_ANGLE) last_ang = a;
      else last_hall_q = (h == HALL_CLOSED_I) ? HALL_CLOSED_I : HALL_OPEN_I;
      if (tent_q != fhsc_pkg::TENT_OFF) begin
        if (h == HALL_CLOSED_I) r.tent_report = fhsc_pkg::RPT_ABN_HALL;
        else if (a < int'(fhsc_pkg::TENT_EXIT_MIN) || a > int'(fhsc_pkg::TENT_EXIT_MAX))
          r.tent_report = fhsc_pkg::RPT_ABN_ANGLE;
        if (r.tent_report != fhsc_pkg::RPT_NONE) begin
          nx = classify_fold(a, h);
          fold_q = nx;
          tent_q = fhsc_pkg::TENT_OFF;
          status_q = (nx == fhsc_pkg::FS_FOLDED) ? fhsc_pkg::ST_FOLDED : fhsc_pkg::ST_UNKNOWN;
          r.hover_event = fhsc_pkg::HOV_CANCEL;
          r.hover_hall_closed = (h != HALL_OPEN_I);
          r.wake_request = 1'b1;
        end
      end else begin
        fold_q = classify_fold(a, h);
      end
    end else if (it.op == fhsc_pkg::OP_TENT && it.tent_type != TENT_BAD &&
                 it.tent_type != tent_q) begin
      tent_q = it.tent_type;
      if (it.tent_type != fhsc_pkg::TENT_OFF) begin
        r.tent_report = fhsc_pkg::RPT_ENTER;
        fold_q = fhsc_pkg::FS_FOLDED;
        status_q = (it.tent_type == fhsc_pkg::TENT_ON) ? fhsc_pkg::ST_TENT
                                                       : fhsc_pkg::ST_HOVER;
        r.hover_event = (it.tent_type == fhsc_pkg::TENT_ON) ? fhsc_pkg::HOV_TENT
                                                            : fhsc_pkg::HOV_HOVER;
      end else begin
        if (h == HALL_CLOSED_I) last_ang = floor_q;
        // negative hall means: classify with the stored hall
        nx = classify_fold(last_ang, (h < 0) ? last_hall_q : h);
        status_q = (nx == fhsc_pkg::FS_FOLDED) ? fhsc_pkg::ST_FOLDED : fhsc_pkg::ST_UNKNOWN;
        fold_q = nx;
        r.tent_report = fhsc_pkg::RPT_EXIT;
        r.hover_event = fhsc_pkg::HOV_CANCEL;
        r.hover_hall_closed = (h != HALL_OPEN_I);
      end
    end
    r.fold_state = fold_q;
    r.tent_mode = tent_q;
    r.device_status = status_q;
    return r;
  endfunction

  function automatic dir_row_t plain_row(logic [1:0] op, int ang, int hall, logic [1:0] tt);
    dir_row_t r;
    r.stim.op = op;
    r.stim.angle = fhsc_pkg::ANGLE_BITS'(ang);
    r.stim.hall = 2'(hall);
    r.stim.tent_type = tt;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [1:0] op, int ang, int hall, logic [1:0] tt,
                                         fhsc_pkg::out_item_t res);
    dir_row_t r;
    r = plain_row(op, ang, hall, tt);
    r.typed = 1'b1;
    r.res = res;
    return r;
  endfunction

  task automatic send_event(fhsc_pkg::in_item_t it, logic typed,
                            fhsc_pkg::out_item_t typed_res);
    fhsc_pkg::out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.op <= it.op;
    in_bus.angle <= it.angle;
    in_bus.hall <= it.hall;
    in_bus.tent_type <= it.tent_type;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pred = predict_event(it);
    result_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(logic [fhsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fhsc_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      fhsc_pkg::CFG_ANGLE_FLOOR:    floor_q = int'($signed(data));
      fhsc_pkg::CFG_OPEN_HALF_MIN:  thr_open = int'(data[fhsc_pkg::THR_W-1:0]);
      fhsc_pkg::CFG_CLOSE_HALF_MIN: thr_close = int'(data[fhsc_pkg::THR_W-1:0]);
      fhsc_pkg::CFG_HALF_MAX:       thr_half = int'(data[fhsc_pkg::THR_W-1:0]);
      fhsc_pkg::CFG_HYST_BAND:      thr_band = int'(data[fhsc_pkg::THR_W-1:0]);
      fhsc_pkg::CFG_LARGE_ANGLE:    thr_large = int'(data[fhsc_pkg::THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // result side: random back-pressure, compare each beat with the oldest expected result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_cnt++;
        end else begin
          want_res = result_q.pop_front();
          got_res = '{out_bus.fold_state, out_bus.tent_mode, out_bus.device_status,
                      out_bus.tent_report, out_bus.hover_event, out_bus.hover_hall_closed,
                      out_bus.wake_request};
          check_field("fold_state", 3'(want_res.fold_state), 3'(got_res.fold_state));
          check_field("tent_mode", 3'(want_res.tent_mode), 3'(got_res.tent_mode));
          check_field("device_status", 3'(want_res.device_status),
                      3'(got_res.device_status));
          check_field("tent_report", want_res.tent_report, got_res.tent_report);
          check_field("hover_event", 3'(want_res.hover_event), 3'(got_res.hover_event));
          check_field("hover_hall_closed", 3'(want_res.hover_hall_closed),
                      3'(got_res.hover_hall_closed));
          check_field("wake_request", 3'(want_res.wake_request),
                      3'(got_res.wake_request));
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    fhsc_pkg::in_item_t it;
    int n, pick, base, fl, oh, ch, hm, hb, la;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = fhsc_pkg::OP_ANGLE;
    in_bus.angle = '0;
    in_bus.hall = '0;
    in_bus.tent_type = fhsc_pkg::TENT_OFF;
    out_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = fhsc_pkg::CFG_ANGLE_FLOOR;
    cfg_wdata = '0;

    floor_q = int'($signed(fhsc_pkg::RST_ANGLE_FLOOR));
    thr_open = int'(fhsc_pkg::RST_OPEN_HALF_MIN);
    thr_close = int'(fhsc_pkg::RST_CLOSE_HALF_MIN);
    thr_half = int'(fhsc_pkg::RST_HALF_MAX);
    thr_band = int'(fhsc_pkg::RST_HYST_BAND);
    thr_large = int'(fhsc_pkg::RST_LARGE_ANGLE);
    fold_q = fhsc_pkg::FS_UNKNOWN;
    wide_mode = 1'b0;
    last_ang = floor_q;
    last_hall_q = HALL_OPEN_I;
    tent_q = fhsc_pkg::TENT_OFF;
    status_q = fhsc_pkg::ST_UNKNOWN;

    dir_tab = '{
      typed_row(OP_IGNORED, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_UNKNOWN, fhsc_pkg::TENT_OFF,
                fhsc_pkg::ST_UNKNOWN, fhsc_pkg::RPT_NONE, fhsc_pkg::HOV_NONE, 1'b0, 1'b0}),
      typed_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_ON,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_ON,
                fhsc_pkg::ST_TENT, fhsc_pkg::RPT_ENTER, fhsc_pkg::HOV_TENT, 1'b0, 1'b0}),
      // repeated request and tent type 3 change nothing
      typed_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_ON,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_ON,
                fhsc_pkg::ST_TENT, fhsc_pkg::RPT_NONE, fhsc_pkg::HOV_NONE, 1'b0, 1'b0}),
      typed_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, TENT_BAD,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_ON,
                fhsc_pkg::ST_TENT, fhsc_pkg::RPT_NONE, fhsc_pkg::HOV_NONE, 1'b0, 1'b0}),
      typed_row(fhsc_pkg::OP_ANGLE, 900, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_ON,
                fhsc_pkg::ST_TENT, fhsc_pkg::RPT_NONE, fhsc_pkg::HOV_NONE, 1'b0, 1'b0}),
      typed_row(fhsc_pkg::OP_HALL, 0, fhsc_pkg::HALL_CLOSED, fhsc_pkg::TENT_OFF,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_OFF,
                fhsc_pkg::ST_FOLDED, fhsc_pkg::RPT_ABN_HALL, fhsc_pkg::HOV_CANCEL,
                1'b1, 1'b1}),
      // below the floor: state kept
      typed_row(fhsc_pkg::OP_ANGLE, -2048, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_OFF,
                fhsc_pkg::ST_FOLDED, fhsc_pkg::RPT_NONE, fhsc_pkg::HOV_NONE, 1'b0, 1'b0}),
      plain_row(fhsc_pkg::OP_ANGLE, 2047, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_ANGLE, 1550, HALL_STORED, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_HALL, 1000, HALL_STORED_ALT, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_HALL, 250, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_ANGLE, 300, fhsc_pkg::HALL_CLOSED, fhsc_pkg::TENT_OFF),
      typed_row(fhsc_pkg::OP_TENT, 0, HALL_STORED, fhsc_pkg::TENT_HOVER,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_HOVER,
                fhsc_pkg::ST_HOVER, fhsc_pkg::RPT_ENTER, fhsc_pkg::HOV_HOVER, 1'b0, 1'b0}),
      typed_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_ON,
                fhsc_pkg::out_item_t'{fhsc_pkg::FS_FOLDED, fhsc_pkg::TENT_ON,
                fhsc_pkg::ST_TENT, fhsc_pkg::RPT_ENTER, fhsc_pkg::HOV_TENT, 1'b0, 1'b0}),
      plain_row(fhsc_pkg::OP_ANGLE, 49, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_HOVER),
      plain_row(fhsc_pkg::OP_ANGLE, 1751, HALL_STORED, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_ON),
      plain_row(fhsc_pkg::OP_ANGLE, 50, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_ANGLE, 1750, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_CLOSED, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_ON),
      plain_row(fhsc_pkg::OP_TENT, 0, HALL_STORED, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_HOVER),
      plain_row(fhsc_pkg::OP_TENT, 0, HALL_STORED_ALT, fhsc_pkg::TENT_OFF),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_ON),
      plain_row(fhsc_pkg::OP_TENT, 0, fhsc_pkg::HALL_OPEN, fhsc_pkg::TENT_OFF)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_event(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].res);

    for (int round = 0; round < ROUNDS; round++) begin
      if (round > 0) begin
        in_bus.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        case (round)
          1: begin fl = -2048; oh = 0; ch = 0; hm = 0; hb = 0; la = 0; end
          2: begin fl = 2047; oh = 2047; ch = 2047; hm = 2047; hb = 2047; la = 2047; end
          3: begin fl = -1800; oh = 0; ch = 1800; hm = 1800; hb = 1800; la = 0; end
          7: begin
            fl = $urandom_range(4095); oh = $urandom_range(4095); ch = $urandom_range(4095);
            hm = $urandom_range(4095); hb = $urandom_range(4095); la = $urandom_range(4095);
          end
          default: begin
            fl = $urandom_range(3600) - 1800; oh = $urandom_range(600);
            ch = $urandom_range(400, 1200); hm = $urandom_range(1000, 1800);
            hb = $urandom_range(200); la = $urandom_range(1800);
          end
        endcase
        write_reg(fhsc_pkg::CFG_ANGLE_FLOOR, fhsc_pkg::CFG_DATA_W'(fl));
        write_reg(fhsc_pkg::CFG_OPEN_HALF_MIN, fhsc_pkg::CFG_DATA_W'(oh));
        write_reg(fhsc_pkg::CFG_CLOSE_HALF_MIN, fhsc_pkg::CFG_DATA_W'(ch));
        write_reg(fhsc_pkg::CFG_HALF_MAX, fhsc_pkg::CFG_DATA_W'(hm));
        write_reg(fhsc_pkg::CFG_HYST_BAND, fhsc_pkg::CFG_DATA_W'(hb));
        write_reg(fhsc_pkg::CFG_LARGE_ANGLE, fhsc_pkg::CFG_DATA_W'(la));
        // unused index: must be ignored
        write_reg($urandom_range(1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  fhsc_pkg::CFG_DATA_W'($urandom_range(4095)));
        cfg_we <= 1'b0;
      end

      case (round % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase

      n = 0;
      while (n < ROUND_ITEMS) begin
        pick = $urandom_range(99);
        it.op = (pick < 45) ? fhsc_pkg::OP_ANGLE : (pick < 70) ? fhsc_pkg::OP_HALL :
                (pick < 95) ? fhsc_pkg::OP_TENT : OP_IGNORED;
        pick = $urandom_range(9);
        if (pick < 6) begin
          // aim near a boundary so hysteresis and exit edges are hit
          case ($urandom_range(9))
            0: base = floor_q;
            1: base = thr_open;
            2: base = thr_open + thr_band;
            3: base = thr_close;
            4: base = thr_close + thr_band;
            5: base = thr_half;
            6: base = thr_half - thr_band;
            7: base = thr_large;
            8: base = int'(fhsc_pkg::TENT_EXIT_MIN);
            default: base = int'(fhsc_pkg::TENT_EXIT_MAX);
          endcase
          it.angle = fhsc_pkg::ANGLE_BITS'(base + $urandom_range(4) - 2);
        end else if (pick < 9) begin
          it.angle = fhsc_pkg::ANGLE_BITS'($urandom_range(3600) - 1800);
        end else begin
          it.angle = fhsc_pkg::ANGLE_BITS'($urandom);
        end
        pick = $urandom_range(99);
        it.hall = (pick < 45) ? fhsc_pkg::HALL_OPEN : (pick < 85) ? fhsc_pkg::HALL_CLOSED :
                  (pick < 93) ? 2'(HALL_STORED) : 2'(HALL_STORED_ALT);
        it.tent_type = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : TENT_BAD;
        send_event(it, 1'b0, '0);
        if (it.op != OP_IGNORED) n++;
      end
    end

    in_bus.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
